@@ rtl/ppbf_pkg.sv @@
package ppbf_pkg;

    // fixed field widths of the item channels
    localparam int OP_W     = 3;
    localparam int ID_W     = 4;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 13;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE      = 3'd0,
        OP_WRITE       = 3'd1,
        OP_READ        = 3'd2,
        OP_DUP_READ    = 3'd3,
        OP_DUP_WRITE   = 3'd4,
        OP_CLOSE_READ  = 3'd5,
        OP_CLOSE_WRITE = 3'd6
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_EOF     = 3'd3,
        ST_BROKEN  = 3'd4,
        ST_NOFREE  = 3'd5,
        ST_NOTUSED = 3'd6,
        ST_REFERR  = 3'd7
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming item, read its pipe record
        logic execute;  // update record and byte store
        logic finish;   // load the result register
    } t_dp_cmd;

endpackage

@@ rtl/ppbf_if.sv @@
interface ppbf_in_if;
    logic                          valid;
    logic                          ready;
    logic [ppbf_pkg::OP_W-1:0]     opcode;
    logic [ppbf_pkg::ID_W-1:0]     pipe_id;
    logic [ppbf_pkg::DATA_W-1:0]   data_in;
    logic                          last_of_transfer;

    modport source (output valid, opcode, pipe_id, data_in, last_of_transfer, input ready);
    modport sink   (input valid, opcode, pipe_id, data_in, last_of_transfer, output ready);
endinterface

interface ppbf_out_if;
    logic                          valid;
    logic                          ready;
    logic [ppbf_pkg::STATUS_W-1:0] status;
    logic [ppbf_pkg::DATA_W-1:0]   data_out;
    logic [ppbf_pkg::ID_W-1:0]     pipe_id_out;
    logic [ppbf_pkg::FILL_W-1:0]   fill_level;
    logic                          last_out;

    modport source (output valid, status, data_out, pipe_id_out, fill_level, last_out,
                    input ready);
    modport sink   (input valid, status, data_out, pipe_id_out, fill_level, last_out,
                    output ready);
endinterface

@@ rtl/ppbf_ctrl.sv @@
module ppbf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output ppbf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_FIN) && out_free);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = accept;
        o_cmd.execute = 1'b0;
        o_cmd.finish  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = accept ? S_EXEC : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // an accepted item is executed on the next cycle
    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.execute)
        else $error("item captured but not executed");

    // execution never overlaps a capture
    a_exec_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |-> !o_cmd.capture)
        else $error("capture during execution");

    // a finished item shows up as a valid result
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished item not presented");

    // the result register is never overwritten while its item waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.finish)
        else $error("pending result overwritten");

endmodule

@@ rtl/ppbf_dp.sv @@
module ppbf_dp #(
    parameter int PIPE_COUNT   = 16,
    parameter int BUFFER_BYTES = 4096,
    parameter int REF_BITS     = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppbf_pkg::t_dp_cmd             i_cmd,
    input  logic [ppbf_pkg::OP_W-1:0]     i_opcode,
    input  logic [ppbf_pkg::ID_W-1:0]     i_pipe_id,
    input  logic [ppbf_pkg::DATA_W-1:0]   i_data_in,
    input  logic                          i_last,
    output logic [ppbf_pkg::STATUS_W-1:0] o_status,
    output logic [ppbf_pkg::DATA_W-1:0]   o_data_out,
    output logic [ppbf_pkg::ID_W-1:0]     o_pipe_id_out,
    output logic [ppbf_pkg::FILL_W-1:0]   o_fill_level,
    output logic                          o_last_out
);

    localparam int PW     = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
    localparam int POS_W  = $clog2(BUFFER_BYTES);
    localparam int HELD_W = $clog2(BUFFER_BYTES + 1);
    localparam int SUM_W  = POS_W + 1;
    localparam int ADDR_W = $clog2(PIPE_COUNT * BUFFER_BYTES);
    localparam int DEPTH  = PIPE_COUNT * BUFFER_BYTES;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [HELD_W-1:0]   held;
        logic [REF_BITS-1:0] rd_refs;
        logic [REF_BITS-1:0] wr_refs;
    } t_rec;

    // per-pipe records and byte store
    t_rec                        rec_mem   [PIPE_COUNT];
    logic [ppbf_pkg::DATA_W-1:0] store_mem [DEPTH];

    logic [PIPE_COUNT-1:0]       r_alloc;
    logic                        r_free_any;
    logic [PW-1:0]               r_free_idx;
    logic                        free_any;
    logic [PW-1:0]               free_idx;

    // latched item
    logic [ppbf_pkg::OP_W-1:0]   r_op;
    logic [ppbf_pkg::ID_W-1:0]   r_id;
    logic [ppbf_pkg::DATA_W-1:0] r_din;
    logic                        r_last;
    logic                        r_hit;
    t_rec                        r_rec;
    logic                        in_range;

    // execute results
    logic [ppbf_pkg::STATUS_W-1:0] r_res_status;
    logic [ppbf_pkg::ID_W-1:0]     r_res_id;
    logic [ppbf_pkg::FILL_W-1:0]   r_res_fill;
    logic                          r_rd_ok;
    logic [ppbf_pkg::DATA_W-1:0]   r_rd_byte;

    // execute logic
    t_rec                          n_rec;
    logic                          rec_we;
    logic                          set_alloc;
    logic                          clr_alloc;
    logic [ppbf_pkg::STATUS_W-1:0] n_status;
    logic [ppbf_pkg::ID_W-1:0]     n_id_out;
    logic [ppbf_pkg::FILL_W-1:0]   n_fill;
    logic                          st_we;
    logic                          st_re;
    logic [PW-1:0]                 pidx;
    logic [SUM_W-1:0]              tail_sum;
    logic [POS_W-1:0]              tail;
    logic [POS_W-1:0]              offs;
    logic [ADDR_W-1:0]             st_addr;

    assign in_range = 32'(i_pipe_id) < PIPE_COUNT;

    // lowest free pipe
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = PIPE_COUNT - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                free_any = 1'b1;
                free_idx = PW'(i);
            end
        end
    end

    assign tail_sum = SUM_W'(r_rec.pos) + SUM_W'(r_rec.held);
    assign tail     = (tail_sum >= SUM_W'(BUFFER_BYTES))
                    ? POS_W'(tail_sum - SUM_W'(BUFFER_BYTES)) : POS_W'(tail_sum);
    assign pidx     = (r_op == ppbf_pkg::OP_CREATE) ? r_free_idx : PW'(r_id);
    assign offs     = (r_op == ppbf_pkg::OP_WRITE) ? tail : r_rec.pos;
    assign st_addr  = ADDR_W'(pidx) * ADDR_W'(BUFFER_BYTES) + ADDR_W'(offs);

    always_comb begin
        n_rec     = r_rec;
        rec_we    = 1'b0;
        set_alloc = 1'b0;
        clr_alloc = 1'b0;
        n_status  = ppbf_pkg::ST_OK;
        n_id_out  = r_id;
        n_fill    = '0;
        st_we     = 1'b0;
        st_re     = 1'b0;
        if (r_op == ppbf_pkg::OP_CREATE) begin
            if (r_free_any) begin
                set_alloc     = 1'b1;
                rec_we        = 1'b1;
                n_rec.pos     = '0;
                n_rec.held    = '0;
                n_rec.rd_refs = REF_BITS'(1);
                n_rec.wr_refs = REF_BITS'(1);
                n_id_out      = ppbf_pkg::ID_W'(r_free_idx);
            end else begin
                n_status = ppbf_pkg::ST_NOFREE;
                n_id_out = '0;
            end
        end else if (!r_hit) begin
            n_status = ppbf_pkg::ST_NOTUSED;
        end else begin
            unique case (r_op)
                ppbf_pkg::OP_WRITE: begin
                    if (r_rec.rd_refs == '0) begin
                        n_status = ppbf_pkg::ST_BROKEN;
                    end else if (r_rec.held >= HELD_W'(BUFFER_BYTES)) begin
                        n_status = ppbf_pkg::ST_FULL;
                    end else begin
                        st_we      = 1'b1;
                        rec_we     = 1'b1;
                        n_rec.held = r_rec.held + HELD_W'(1);
                    end
                end
                ppbf_pkg::OP_READ: begin
                    if (r_rec.held == '0) begin
                        n_status = (r_rec.wr_refs == '0) ? ppbf_pkg::ST_EOF
                                                         : ppbf_pkg::ST_EMPTY;
                    end else begin
                        st_re      = 1'b1;
                        rec_we     = 1'b1;
                        n_rec.pos  = (r_rec.pos == POS_W'(BUFFER_BYTES - 1))
                                   ? '0 : r_rec.pos + POS_W'(1);
                        n_rec.held = r_rec.held - HELD_W'(1);
                    end
                end
                ppbf_pkg::OP_DUP_READ: begin
                    if (&r_rec.rd_refs) begin
                        n_status = ppbf_pkg::ST_REFERR;
                    end else begin
                        rec_we        = 1'b1;
                        n_rec.rd_refs = r_rec.rd_refs + REF_BITS'(1);
                    end
                end
                ppbf_pkg::OP_DUP_WRITE: begin
                    if (&r_rec.wr_refs) begin
                        n_status = ppbf_pkg::ST_REFERR;
                    end else begin
                        rec_we        = 1'b1;
                        n_rec.wr_refs = r_rec.wr_refs + REF_BITS'(1);
                    end
                end
                ppbf_pkg::OP_CLOSE_READ: begin
                    if (r_rec.rd_refs == '0) begin
                        n_status = ppbf_pkg::ST_REFERR;
                    end else begin
                        rec_we        = 1'b1;
                        n_rec.rd_refs = r_rec.rd_refs - REF_BITS'(1);
                        clr_alloc     = (n_rec.rd_refs == '0) && (r_rec.wr_refs == '0);
                    end
                end
                ppbf_pkg::OP_CLOSE_WRITE: begin
                    if (r_rec.wr_refs == '0) begin
                        n_status = ppbf_pkg::ST_REFERR;
                    end else begin
                        rec_we        = 1'b1;
                        n_rec.wr_refs = r_rec.wr_refs - REF_BITS'(1);
                        clr_alloc     = (n_rec.wr_refs == '0) && (r_rec.rd_refs == '0);
                    end
                end
                default: ;
            endcase
            n_fill = ppbf_pkg::FILL_W'(n_rec.held);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc    <= '0;
            r_free_any <= 1'b1;
            r_free_idx <= '0;
        end else begin
            r_free_any <= free_any;
            r_free_idx <= free_idx;
            if (i_cmd.execute && set_alloc) r_alloc[pidx] <= 1'b1;
            if (i_cmd.execute && clr_alloc) r_alloc[pidx] <= 1'b0;
        end
    end

    // record memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_rec <= rec_mem[PW'(i_pipe_id)];
        if (i_cmd.execute && rec_we) rec_mem[pidx] <= n_rec;
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && st_we) store_mem[st_addr] <= r_din;
        if (i_cmd.execute && st_re) r_rd_byte <= store_mem[st_addr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_id   <= i_pipe_id;
            r_din  <= i_data_in;
            r_last <= i_last;
            r_hit  <= in_range && r_alloc[PW'(i_pipe_id)];
        end
        if (i_cmd.execute) begin
            r_res_status <= n_status;
            r_res_id     <= n_id_out;
            r_res_fill   <= n_fill;
            r_rd_ok      <= st_re;
        end
        if (i_cmd.finish) begin
            o_status      <= r_res_status;
            o_data_out    <= r_rd_ok ? r_rd_byte : '0;
            o_pipe_id_out <= r_res_id;
            o_fill_level  <= r_res_fill;
            o_last_out    <= r_last;
        end
    end

endmodule

@@ rtl/pipe_pool_byte_fifo_top.sv @@
// pool of PIPE_COUNT byte pipes, each a ring buffer of BUFFER_BYTES bytes with
// reader and writer reference counts of REF_BITS bits; every item on i_op is one
// operation (create, write byte, read byte, dup or close a reader or writer) and
// yields exactly one result item on o_res carrying a status code, the byte read,
// the pipe number, the fill level after the operation and the echoed last flag.
// an item is handled in steps: at capture its pipe record is read from the
// record memory, at execute the record and the byte store are updated or read,
// and at finish the result is loaded into an output register; the next item is
// accepted in the same cycle as finish, so a new item is taken while the last
// result is loaded, and finish waits while o_res holds back an earlier result.
// pipes are marked free at reset by flip-flops, so no clearing pass is needed
// and items are accepted from the first cycle after reset. a read only returns
// bytes written since the pipe was created

module pipe_pool_byte_fifo_top #(
    parameter int PIPE_COUNT   = 16,
    parameter int BUFFER_BYTES = 4096,
    parameter int REF_BITS     = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppbf_in_if.sink    i_op,
    ppbf_out_if.source o_res
);

    ppbf_pkg::t_dp_cmd cmd;   // sequencing from the controller

    // controller: accept, execute, present result
    ppbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_op.valid),
        .i_out_ready (o_res.ready),
        .o_in_ready  (i_op.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd)
    );

    // datapath: pipe records, byte store and result register
    ppbf_dp #(
        .PIPE_COUNT   (PIPE_COUNT),
        .BUFFER_BYTES (BUFFER_BYTES),
        .REF_BITS     (REF_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_op.opcode),
        .i_pipe_id     (i_op.pipe_id),
        .i_data_in     (i_op.data_in),
        .i_last        (i_op.last_of_transfer),
        .o_status      (o_res.status),
        .o_data_out    (o_res.data_out),
        .o_pipe_id_out (o_res.pipe_id_out),
        .o_fill_level  (o_res.fill_level),
        .o_last_out    (o_res.last_out)
    );

endmodule
